// File: hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package dq_pkg;

    // Storage geometry.
    localparam int DEPTH    = 16;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int HANDLE_W = 32;

    // Field widths of the channels.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic apply;       // execute the command on the request channel
        logic load_direct; // load the result register from the computed result
        logic load_ram;    // load the result register from the store read data
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_read;   // current command pops a stored handle
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/dq_if.sv
// Request and response channel interfaces of the double-ended queue.
`default_nettype none

interface dq_req_if;
    logic                          valid;
    logic                          ready;
    logic [dq_pkg::CMD_W-1:0]      cmd;
    logic [dq_pkg::HANDLE_W-1:0]   push_handle;

    modport source (output valid, output cmd, output push_handle, input ready);
    modport sink   (input valid, input cmd, input push_handle, output ready);
endinterface

interface dq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dq_pkg::HANDLE_W-1:0]   pop_handle;
    logic [dq_pkg::STATUS_W-1:0]   status;
    logic [dq_pkg::CNT_W-1:0]      entry_count;

    modport source (output valid, output pop_handle, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input pop_handle, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/dq_datapath.sv
// Datapath: ring pointers, entry count, handle store and result register.
`default_nettype none

module dq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dq_pkg::ctrl_cmd_t             ctrl,
    output dq_pkg::dp_stat_t                   stat,
    input  wire logic [dq_pkg::CMD_W-1:0]      req_cmd,
    input  wire logic [dq_pkg::HANDLE_W-1:0]   req_handle,
    output logic      [dq_pkg::HANDLE_W-1:0]   pop_handle,
    output logic      [dq_pkg::STATUS_W-1:0]   status,
    output logic      [dq_pkg::CNT_W-1:0]      entry_count
);

    logic [dq_pkg::PTR_W-1:0]    front_reg, front_next;
    logic [dq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [dq_pkg::HANDLE_W-1:0] handle_reg, handle_next;
    dq_pkg::status_t             status_reg, status_next;
    logic [dq_pkg::CNT_W-1:0]    ecount_reg, ecount_next;

    logic                        is_empty, is_full;
    logic [dq_pkg::PTR_W-1:0]    back_pos, last_pos, front_m1, front_p1;
    dq_pkg::status_t             cmd_status;
    logic [dq_pkg::CNT_W-1:0]    cmd_count;
    logic [dq_pkg::PTR_W-1:0]    cmd_front;
    logic                        wr_en, rd_en;
    logic [dq_pkg::PTR_W-1:0]    wr_addr, rd_addr;
    logic [dq_pkg::HANDLE_W-1:0] rd_data;

    // Ring positions around the live entries.
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign back_pos = front_reg + count_reg[dq_pkg::PTR_W-1:0];
    assign last_pos = back_pos - dq_pkg::PTR_W'(1);
    assign front_m1 = front_reg - dq_pkg::PTR_W'(1);
    assign front_p1 = front_reg + dq_pkg::PTR_W'(1);

    // Command decode: new pointers, store access and status.
    always_comb
    begin
        cmd_status       = dq_pkg::ST_DONE;
        cmd_count        = count_reg;
        cmd_front        = front_reg;
        wr_en            = 1'b0;
        wr_addr          = back_pos;
        rd_en            = 1'b0;
        rd_addr          = front_reg;
        stat.need_read   = 1'b0;
        case (dq_pkg::cmd_t'(req_cmd))
            dq_pkg::CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    cmd_status = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = back_pos;
                    cmd_count = count_reg + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    cmd_status = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = front_m1;
                    cmd_front = front_m1;
                    cmd_count = count_reg + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    cmd_status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = front_reg;
                    cmd_front      = front_p1;
                    cmd_count      = count_reg - dq_pkg::CNT_W'(1);
                    stat.need_read = 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    cmd_status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = last_pos;
                    cmd_count      = count_reg - dq_pkg::CNT_W'(1);
                    stat.need_read = 1'b1;
                end
            end
            dq_pkg::CMD_CLEAR:
            begin
                cmd_count = '0;
                cmd_front = '0;
            end
            default:
            begin
                cmd_status = dq_pkg::ST_DONE;
            end
        endcase
    end

    // Pointer and count update on an applied command.
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (ctrl.apply)
        begin
            front_next = cmd_front;
            count_next = cmd_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Handle store.
    dq_ram #(
        .WIDTH (dq_pkg::HANDLE_W),
        .DEPTH (dq_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.apply && wr_en),
        .waddr (wr_addr),
        .wdata (req_handle),
        .re    (ctrl.apply && rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Result register: loaded directly or from the store read data.
    always_comb
    begin
        handle_next = handle_reg;
        status_next = status_reg;
        ecount_next = ecount_reg;
        if (ctrl.load_direct)
        begin
            handle_next = '0;
            status_next = cmd_status;
            ecount_next = cmd_count;
        end
        else if (ctrl.load_ram)
        begin
            handle_next = rd_data;
            status_next = dq_pkg::ST_DONE;
            ecount_next = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        status_reg <= status_next;
        ecount_reg <= ecount_next;
    end

    assign pop_handle  = handle_reg;
    assign status      = status_reg;
    assign entry_count = ecount_reg;

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("entry count above capacity");

endmodule

`default_nettype wire

// File: hdl/dq_ctrl.sv
// Controller: request acceptance, store read wait and result valid.
`default_nettype none

module dq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    input  wire dq_pkg::dp_stat_t stat,
    output dq_pkg::ctrl_cmd_t     ctrl
);

    dq_pkg::state_t state_reg, state_next;
    logic           valid_reg, valid_next;
    logic           accept;

    // A new command is taken in the idle state when the result register is free or being emptied.
    assign req_ready = (state_reg == dq_pkg::S_IDLE) && (!valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        ctrl.apply       = 1'b0;
        ctrl.load_direct = 1'b0;
        ctrl.load_ram    = 1'b0;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.apply = 1'b1;
                    if (stat.need_read)
                    begin
                        state_next = dq_pkg::S_READ;
                    end
                    else
                    begin
                        ctrl.load_direct = 1'b1;
                    end
                end
            end
            dq_pkg::S_READ:
            begin
                ctrl.load_ram = 1'b1;
                state_next    = dq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    // Result valid: set on a load, cleared when the transfer completes.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.load_direct || ctrl.load_ram)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    assign rsp_valid = valid_reg;

    // A pending store read always finds the result register empty.
    a_read_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::S_READ) |-> !valid_reg)
        else $error("store read with result register occupied");

    // An accepted pop goes to the read wait state.
    a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.need_read) |=> (state_reg == dq_pkg::S_READ))
        else $error("accepted pop did not wait for store data");

    // Every applied command produces a valid result.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.apply |-> ##2 ($past(valid_reg, 1) || valid_reg))
        else $error("applied command produced no result");

endmodule

`default_nettype wire

// File: hdl/double_ended_queue.sv
// Top level of the double-ended queue of item handles.
//
//  Channel  Role    Payload                             Transfer when
//  req      sink    cmd, push_handle                    req.valid && req.ready
//  rsp      source  pop_handle, status, entry_count     rsp.valid && rsp.ready
//
// Pushes, clears, pops on an empty queue and unknown commands load the result register directly.
// A successful pop waits in the read state: the handle store has a registered read port.
// The result register lets a new command enter in the cycle its result is taken.
// Asynchronous reset empties the queue; the handle store is not cleared.
// A stalled result holds its register and blocks further commands.
`default_nettype none

module double_ended_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp
);

    dq_pkg::ctrl_cmd_t ctrl;
    dq_pkg::dp_stat_t  stat;

    // Controller.
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Datapath.
    dq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .req_cmd     (req.cmd),
        .req_handle  (req.push_handle),
        .pop_handle  (rsp.pop_handle),
        .status      (rsp.status),
        .entry_count (rsp.entry_count)
    );

endmodule

`default_nettype wire
